[design/salu_pkg.sv]
// Shared types, opcodes and status codes of the 64-bit signed ALU.
`default_nettype none
package salu_pkg;
	localparam int unsigned W = 64;
	localparam int unsigned QDEPTH = 2;

	localparam logic [7:0] OP_ADD = 8'h01;
	localparam logic [7:0] OP_SUB = 8'h02;
	localparam logic [7:0] OP_MUL = 8'h03;
	localparam logic [7:0] OP_DIV = 8'h04;
	localparam logic [7:0] OP_MOD = 8'h05;
	localparam logic [7:0] OP_SHL = 8'h10;
	localparam logic [7:0] OP_OR  = 8'h11;
	localparam logic [7:0] OP_AND = 8'h12;
	localparam logic [7:0] OP_XOR = 8'h13;
	localparam logic [7:0] OP_CMP = 8'h14;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DIVZ  = 2'd1;
	localparam logic [1:0] ST_BADOP = 2'd2;

	typedef struct packed {
		logic [7:0]          kind;
		logic signed [63:0]  operand_a;
		logic signed [63:0]  operand_b;
	} in_t;

	typedef struct packed {
		logic signed [63:0]  value;
		logic [1:0]          status;
	} out_t;

	typedef enum logic [2:0] {
		C_SIMPLE, C_MUL, C_DIV, C_MOD, C_DIVZ, C_BAD
	} cls_t;

	// One classified operation as it sits in the queue.
	typedef struct packed {
		cls_t         cls;
		logic [63:0]  a;
		logic [63:0]  b;
		logic [63:0]  simple;
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE, B_MUL, B_DIV, B_FIX, B_OUT
	} bstate_t;
endpackage
`default_nettype wire

[design/salu_front.sv]
// Front end: accepts operations, works out the simple ones and queues them.
`default_nettype none
module salu_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid,
	output logic                 stall,
	input  wire salu_pkg::in_t   data,
	output logic                 q_valid,
	input  wire logic            q_take,
	output salu_pkg::op_t        q_op
);
	salu_pkg::op_t            mem_q [salu_pkg::QDEPTH];
	logic                     wp_q, rp_q;
	logic [1:0]               cnt_q;
	salu_pkg::op_t            op;
	logic                     push, pop;
	logic [63:0]              a, b;

	assign a = data.operand_a;
	assign b = data.operand_b;

	always_comb begin
		op.a = a;
		op.b = b;
		op.simple = '0;
		op.cls = salu_pkg::C_SIMPLE;
		case (data.kind)
			salu_pkg::OP_ADD: op.simple = a + b;
			salu_pkg::OP_SUB: op.simple = a - b;
			salu_pkg::OP_MUL: op.cls = salu_pkg::C_MUL;
			salu_pkg::OP_DIV: op.cls = (b == '0) ? salu_pkg::C_DIVZ : salu_pkg::C_DIV;
			salu_pkg::OP_MOD: op.cls = (b == '0) ? salu_pkg::C_DIVZ : salu_pkg::C_MOD;
			salu_pkg::OP_SHL: op.simple = (b < 64'd64) ? (a << b[5:0]) : '0;
			salu_pkg::OP_OR:  op.simple = a | b;
			salu_pkg::OP_AND: op.simple = a & b;
			salu_pkg::OP_XOR: op.simple = a ^ b;
			salu_pkg::OP_CMP: begin
				if (a == b)
					op.simple = '0;
				else if ($signed(a) > $signed(b))
					op.simple = '1;
				else
					op.simple = 64'd1;
			end
			default: op.cls = salu_pkg::C_BAD;
		endcase
	end

	assign stall = (cnt_q == 2'(salu_pkg::QDEPTH));
	assign push = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_take;
	assign q_op = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[design/salu_back.sv]
// Back end: multiplier and divider sequencer, held result and output register.
`default_nettype none
module salu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_take,
	input  wire salu_pkg::op_t   q_op,
	output logic                 valid,
	input  wire logic            stall,
	output salu_pkg::out_t       data
);
	salu_pkg::bstate_t state_q, state_d;
	logic [63:0]  held_q, a_q, b_q, rem_q, quo_q, acc_q;
	logic [6:0]   cnt_q;
	logic         mod_q, qneg_q, rneg_q;
	logic [1:0]   status_q;
	logic [64:0]  trial;
	logic [63:0]  rshift;
	logic [63:0]  ma, mb;
	logic [63:0]  pp;

	assign ma = q_op.a[63] ? -q_op.a : q_op.a;
	assign mb = q_op.b[63] ? -q_op.b : q_op.b;
	assign rshift = {rem_q[62:0], quo_q[63]};
	assign trial = {1'b0, rshift} - {1'b0, b_q};
	// Multiply 16 bits of b per cycle against the full a; low 64 bits only.
	assign pp = a_q * {48'd0, b_q[15:0]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			salu_pkg::B_IDLE:
				if (q_valid) begin
					case (q_op.cls)
						salu_pkg::C_MUL: state_d = salu_pkg::B_MUL;
						salu_pkg::C_DIV, salu_pkg::C_MOD: state_d = salu_pkg::B_DIV;
						default: state_d = salu_pkg::B_OUT;
					endcase
				end
			salu_pkg::B_MUL: if (cnt_q == 7'd3) state_d = salu_pkg::B_OUT;
			salu_pkg::B_DIV: if (cnt_q == 7'd63) state_d = salu_pkg::B_FIX;
			salu_pkg::B_FIX: state_d = salu_pkg::B_OUT;
			salu_pkg::B_OUT: if (!stall) state_d = salu_pkg::B_IDLE;
			default: state_d = salu_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_take = (state_q == salu_pkg::B_IDLE) && q_valid;
		valid = (state_q == salu_pkg::B_OUT);
		data.value = held_q;
		data.status = status_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			salu_pkg::B_IDLE: begin
				a_q <= q_op.a;
				acc_q <= '0;
				if (q_op.cls == salu_pkg::C_DIV || q_op.cls == salu_pkg::C_MOD) begin
					b_q <= mb;
					quo_q <= ma;
					rem_q <= '0;
				end else begin
					b_q <= q_op.b;
				end
				mod_q <= (q_op.cls == salu_pkg::C_MOD);
				qneg_q <= q_op.a[63] ^ q_op.b[63];
				rneg_q <= q_op.a[63];
			end
			salu_pkg::B_MUL: begin
				acc_q <= acc_q + pp;
				a_q <= a_q << 16;
				b_q <= b_q >> 16;
			end
			salu_pkg::B_DIV: begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rshift;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salu_pkg::B_IDLE;
			cnt_q <= '0;
			held_q <= '0;
			status_q <= salu_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_q == state_d) ? cnt_q + 7'd1 : 7'd0;
			if (state_q == salu_pkg::B_IDLE && q_valid) begin
				case (q_op.cls)
					salu_pkg::C_DIVZ: status_q <= salu_pkg::ST_DIVZ;
					salu_pkg::C_BAD: status_q <= salu_pkg::ST_BADOP;
					default: status_q <= salu_pkg::ST_OK;
				endcase
				if (q_op.cls == salu_pkg::C_SIMPLE)
					held_q <= q_op.simple;
			end
			if (state_q == salu_pkg::B_MUL && cnt_q == 7'd3)
				held_q <= acc_q + pp;
			if (state_q == salu_pkg::B_FIX) begin
				if (mod_q)
					held_q <= rneg_q ? -rem_q : rem_q;
				else
					held_q <= qneg_q ? -quo_q : quo_q;
			end
		end
	end
endmodule
`default_nettype wire

[design/signed_alu_64.sv]
// Top level of the 64-bit signed ALU.
// Input channel in_valid/in_stall/in_data carries one operation per beat:
// opcode kind and signed operands operand_a and operand_b.
// Output channel out_valid/out_stall/out_data returns one beat per operation
// with the held result value and a status code.
// A two-entry queue sits between the decoding front end and the execution
// back end, so the front keeps taking beats while a result waits.
// Simple operations go from the queue straight to the held result; multiply
// takes four 64x16 partial product steps, divide and modulo one restoring
// step per quotient bit plus a sign fixup.
// The back end sequencer runs one operation at a time, so it takes the next
// operation from the queue only once the last result beat has left.
// Reset clears the queue, the sequencer and the held result to zero.
// While out_stall is high the result beat holds and the queue fills; when it
// is full, in_stall rises.
`default_nettype none
module signed_alu_64 (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire salu_pkg::in_t    in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output salu_pkg::out_t        out_data
);
	logic           q_valid, q_take;
	salu_pkg::op_t  q_op;

	salu_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(in_stall), .data(in_data),
		.q_valid, .q_take, .q_op
	);

	salu_back u_back (
		.clk, .arst_n,
		.q_valid, .q_take, .q_op,
		.valid(out_valid), .stall(out_stall), .data(out_data)
	);
endmodule
`default_nettype wire

[design/salu_checker.sv]
// Port-level checker for the ALU, bound to the top level.
`default_nettype none
module salu_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire salu_pkg::out_t   out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("illegal status code");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != salu_pkg::ST_OK |->
		out_data.value == $past(out_data.value))
		else $error("held result changed on a failed operation");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("back-to-back result beats");
	// Reset clears the flops that drive out_valid and in_stall, so both stay low in reset.
	a_rst: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !out_valid && !in_stall)
		else $error("handshake active in reset");
endmodule

bind signed_alu_64 salu_checker u_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire

[tb/tb_signed_alu_64.sv]
// Self-checking testbench of the 64-bit signed ALU: directed table, then random operations.
`default_nettype none
module tb_signed_alu_64;
	localparam int NUM_RANDOM = 1500;
	localparam int NUM_DIRECTED = 24;
	localparam logic [63:0] MINV = 64'h8000000000000000;
	localparam logic [63:0] MAXV = 64'h7FFFFFFFFFFFFFFF;
	localparam logic [63:0] ONES = 64'hFFFFFFFFFFFFFFFF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	salu_pkg::in_t in_data;
	logic out_valid;
	logic out_stall;
	salu_pkg::out_t out_data;

	signed_alu_64 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// One row of the directed table; has_val marks a value typed in by hand.
	typedef struct {
		logic [7:0] kind;
		logic [63:0] a;
		logic [63:0] b;
		bit has_val;
		logic [63:0] value;
		logic [1:0] status;
	} row_t;

	row_t rows [NUM_DIRECTED];
	salu_pkg::out_t pending_results [$];
	logic [63:0] alu_held;
	int errors;
	int beats_out;
	int div_ops;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [63:0] mag(input logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	// Computes the ALU result and advances the held result register.
	function automatic salu_pkg::out_t alu_compute(input logic [7:0] kind,
			input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		logic [1:0] st;
		salu_pkg::out_t res;
		r = '0;
		st = salu_pkg::ST_OK;
		case (kind)
			salu_pkg::OP_ADD: r = a + b;
			salu_pkg::OP_SUB: r = a - b;
			salu_pkg::OP_MUL: r = a * b;
			salu_pkg::OP_DIV: begin
				if (b == 0) st = salu_pkg::ST_DIVZ;
				else begin
					r = mag(a) / mag(b);
					if (a[63] ^ b[63]) r = -r;
				end
			end
			salu_pkg::OP_MOD: begin
				if (b == 0) st = salu_pkg::ST_DIVZ;
				else begin
					r = mag(a) % mag(b);
					if (a[63]) r = -r;
				end
			end
			salu_pkg::OP_SHL: r = (b < 64) ? (a << b[5:0]) : '0;
			salu_pkg::OP_OR: r = a | b;
			salu_pkg::OP_AND: r = a & b;
			salu_pkg::OP_XOR: r = a ^ b;
			salu_pkg::OP_CMP: begin
				if (a == b) r = '0;
				else if ($signed(a) > $signed(b)) r = ONES;
				else r = 64'd1;
			end
			default: st = salu_pkg::ST_BADOP;
		endcase
		if (st == salu_pkg::ST_OK) alu_held = r;
		res.value = alu_held;
		res.status = st;
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 7))
			0: return MINV;
			1: return MAXV;
			2: return '0;
			3: return ONES;
			4: return {{56{1'b0}}, 8'($urandom())};
			5: return -{{56{1'b0}}, 8'($urandom())};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [7:0] rand_kind();
		logic [7:0] ops [10] = '{salu_pkg::OP_ADD, salu_pkg::OP_SUB, salu_pkg::OP_MUL,
			salu_pkg::OP_DIV, salu_pkg::OP_MOD, salu_pkg::OP_SHL, salu_pkg::OP_OR,
			salu_pkg::OP_AND, salu_pkg::OP_XOR, salu_pkg::OP_CMP};
		if ($urandom_range(0, 19) == 0) return 8'($urandom());
		return ops[$urandom_range(0, 9)];
	endfunction

	function automatic row_t mk(input logic [7:0] k, input logic [63:0] a,
			input logic [63:0] b, input bit hv, input logic [63:0] v, input logic [1:0] s);
		row_t r;
		r.kind = k;
		r.a = a;
		r.b = b;
		r.has_val = hv;
		r.value = v;
		r.status = s;
		return r;
	endfunction

	// Sends one beat and records its expected result; waits for acceptance.
	task automatic send_op(input logic [7:0] kind, input logic [63:0] a, input logic [63:0] b,
			input bit hv, input logic [63:0] v, input logic [1:0] s);
		salu_pkg::out_t res;
		res = alu_compute(kind, a, b);
		if (hv && (res.value != v || res.status != s)) begin
			$error("directed row kind %0h: typed value %0h/%0d disagrees with predictor %0h/%0d",
				kind, v, s, res.value, res.status);
			errors++;
		end
		in_valid <= 1'b1;
		in_data <= '{kind: kind, operand_a: a, operand_b: b};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(res);
		if (kind == salu_pkg::OP_DIV || kind == salu_pkg::OP_MOD) div_ops++;
	endtask

	task automatic gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Receiver: stalls in its own pattern and checks each accepted beat.
	initial begin
		int mode;
		out_stall = 1'b0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				beats_out++;
				if (pending_results.size() == 0) begin
					$error("unexpected result beat value %0h status %0d",
						out_data.value, out_data.status);
					errors++;
				end else begin
					salu_pkg::out_t e;
					e = pending_results.pop_front();
					if (out_data.value !== e.value) begin
						$error("value: expected %0h, actual %0h", e.value, out_data.value);
						errors++;
					end
					if (out_data.status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, out_data.status);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	initial begin
		int burst;
		int wait_cycles;
		errors = 0;
		beats_out = 0;
		div_ops = 0;
		alu_held = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		rows[0] = mk(8'h00, 64'd5, 64'd6, 1'b1, 64'd0, salu_pkg::ST_BADOP);
		rows[1] = mk(salu_pkg::OP_DIV, 64'd7, 64'd0, 1'b1, 64'd0, salu_pkg::ST_DIVZ);
		rows[2] = mk(salu_pkg::OP_ADD, MAXV, 64'd1, 1'b1, MINV, salu_pkg::ST_OK);
		rows[3] = mk(salu_pkg::OP_SUB, MINV, 64'd1, 1'b1, MAXV, salu_pkg::ST_OK);
		rows[4] = mk(salu_pkg::OP_MUL, MAXV, MAXV, 1'b1, 64'd1, salu_pkg::ST_OK);
		rows[5] = mk(salu_pkg::OP_DIV, MINV, ONES, 1'b1, MINV, salu_pkg::ST_OK);
		rows[6] = mk(salu_pkg::OP_MOD, MINV, ONES, 1'b1, 64'd0, salu_pkg::ST_OK);
		rows[7] = mk(salu_pkg::OP_MOD, 64'd9, 64'd0, 1'b1, 64'd0, salu_pkg::ST_DIVZ);
		rows[8] = mk(salu_pkg::OP_DIV, -64'sd7, 64'd2, 1'b1, -64'sd3, salu_pkg::ST_OK);
		rows[9] = mk(salu_pkg::OP_MOD, -64'sd7, 64'd2, 1'b1, ONES, salu_pkg::ST_OK);
		rows[10] = mk(salu_pkg::OP_MOD, 64'd7, -64'sd2, 1'b1, 64'd1, salu_pkg::ST_OK);
		rows[11] = mk(8'hFF, '0, '0, 1'b1, 64'd1, salu_pkg::ST_BADOP);
		rows[12] = mk(salu_pkg::OP_SHL, 64'd1, 64'd63, 1'b1, MINV, salu_pkg::ST_OK);
		rows[13] = mk(salu_pkg::OP_SHL, ONES, 64'd64, 1'b1, 64'd0, salu_pkg::ST_OK);
		rows[14] = mk(salu_pkg::OP_SHL, 64'd1, ONES, 1'b1, 64'd0, salu_pkg::ST_OK);
		rows[15] = mk(salu_pkg::OP_SHL, MAXV, 64'd0, 1'b1, MAXV, salu_pkg::ST_OK);
		rows[16] = mk(salu_pkg::OP_OR, 64'h0F0F0F0F0F0F0F0F, MINV, 1'b0, '0, salu_pkg::ST_OK);
		rows[17] = mk(salu_pkg::OP_AND, ONES, 64'h123456789ABCDEF0, 1'b0, '0,
			salu_pkg::ST_OK);
		rows[18] = mk(salu_pkg::OP_XOR, ONES, 64'h5555555555555555, 1'b0, '0,
			salu_pkg::ST_OK);
		rows[19] = mk(salu_pkg::OP_CMP, 64'd3, 64'd3, 1'b1, 64'd0, salu_pkg::ST_OK);
		rows[20] = mk(salu_pkg::OP_CMP, MAXV, MINV, 1'b1, ONES, salu_pkg::ST_OK);
		rows[21] = mk(salu_pkg::OP_CMP, MINV, MAXV, 1'b1, 64'd1, salu_pkg::ST_OK);
		rows[22] = mk(salu_pkg::OP_DIV, MAXV, MINV, 1'b1, 64'd0, salu_pkg::ST_OK);
		rows[23] = mk(salu_pkg::OP_MUL, MINV, ONES, 1'b1, MINV, salu_pkg::ST_OK);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_op(rows[i].kind, rows[i].a, rows[i].b, rows[i].has_val,
				rows[i].value, rows[i].status);
			gap($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0);
		end
		burst = 0;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			logic [7:0] k;
			logic [63:0] b;
			k = rand_kind();
			b = rand64();
			// Shift amounts mostly in range so the shifter itself gets exercised.
			if (k == salu_pkg::OP_SHL && $urandom_range(0, 3) != 0)
				b = 64'($urandom_range(0, 63));
			send_op(k, rand64(), b, 1'b0, '0, salu_pkg::ST_OK);
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				gap($urandom_range(0, 1) ? $urandom_range(1, 30) : 0);
			end else burst--;
		end
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		$display("Ran %0d directed and %0d random operations, %0d of them divide or modulo.",
			NUM_DIRECTED, NUM_RANDOM, div_ops);
		$display("Checked %0d result beats under random input gaps and output stalls.",
			beats_out);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			if (pending_results.size() != 0)
				$error("%0d expected results never arrived", pending_results.size());
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
design/salu_pkg.sv
design/salu_front.sv
design/salu_back.sv
design/signed_alu_64.sv
design/salu_checker.sv
tb/tb_signed_alu_64.sv
